[design/sacts_pkg.sv]
// ----------------------------------------------------------------------------
// sacts_pkg
// Shared types and constants of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sacts_pkg;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;

    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 32;
    localparam int SET_W    = 8;
    localparam int CNT_W    = 32;
    localparam int LFSR_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int OUT_DATA_W = SET_W + TAG_W + 2 * CNT_W;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Replacement policy codes.
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS    = 3'd4;

    // One classified access waiting between front and back.
    typedef struct packed {
        logic             alloc;
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
    } acc_t;

    // Settings the back end needs.
    typedef struct packed {
        logic [1:0] policy;
        logic [3:0] ways;
    } back_cfg_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic b;
        b = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {b, v[LFSR_W-1:1]};
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

[design/set_assoc_cache_tag_store.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Tag store of a set-associative cache with FIFO, LRU or random replacement.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one access: s_tuser gives the command
// (0 read, 1 write) and s_tdata the 32-bit byte address. For every item one
// result item leaves on the master stream: m_tuser is the hit flag and
// m_tdata carries the set index, the tag and the saturating hit and miss
// totals. The configuration channel writes one register per handshake and
// is always ready; it should only be used while no access is in flight.
// The front end classifies an access in the accepting cycle and parks it in
// a two-item queue. The back end reads the set row from RAM, looks the tag
// up, and writes the updated row back; when random replacement evicts, the
// victim is the LFSR value modulo the way count, worked out one bit a cycle.
// That read-modify-write of one RAM row per access sets the throughput. A
// stalled receiver holds the result register; the back end then waits, the
// queue fills and s_tready drops. Reset marks every set invalid through one
// flag per set, loads the LFSR seed, clears the totals and restores the
// register defaults.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store #(
    parameter int MAX_SETS = sacts_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sacts_pkg::MAX_WAYS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sacts_pkg::ADDR_W-1:0]         s_tdata,   // address
    input  logic                                 s_tuser,   // command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sacts_pkg::OUT_DATA_W-1:0]     m_tdata,   // set_index, tag_value, hit_total, miss_total
    output logic                                 m_tuser,   // hit
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sacts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sacts_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sacts_pkg::*;

    logic [1:0]  policy_reg;
    logic        wb_reg;
    logic [4:0]  offset_reg;
    logic [3:0]  index_reg;
    logic [3:0]  ways_reg;
    back_cfg_t   bcfg;
    logic        q_valid, q_pop;
    acc_t        q_data;

    assign cfg_ready = 1'b1;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIFO;
            wb_reg     <= 1'b1;
            offset_reg <= 5'd6;
            index_reg  <= 4'd0;
            ways_reg   <= 4'd8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[1:0];
                REG_WB:     wb_reg     <= cfg_data[0];
                REG_OFFSET: offset_reg <= cfg_data;
                REG_INDEX:  index_reg  <= cfg_data[3:0];
                REG_WAYS:   ways_reg   <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    assign bcfg.policy = policy_reg;
    assign bcfg.ways   = ways_reg;

    sacts_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .write_back  (wb_reg),
        .offset_bits (offset_reg),
        .set_bits    (index_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data)
    );

    sacts_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (bcfg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[design/sacts_ram.sv]
// ----------------------------------------------------------------------------
// sacts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/sacts_front.sv]
// ----------------------------------------------------------------------------
// sacts_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ----------------------------------------------------------------------------
module sacts_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 write_back,
    input  logic [4:0]                           offset_bits,
    input  logic [3:0]                           set_bits,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sacts_pkg::ADDR_W-1:0]         s_tdata,  // address
    input  logic                                 s_tuser,  // command: 0 read, 1 write
    output logic                                 q_valid,
    input  logic                                 q_pop,
    output sacts_pkg::acc_t                      q_data
);
    import sacts_pkg::*;

    logic [3:0]        ib;
    logic [5:0]        shift;
    logic [SET_W-1:0]  mask;
    acc_t              entry;
    acc_t              slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push;

    always_comb
    begin
        ib    = (set_bits > 4'd8) ? 4'd8 : set_bits;
        shift = 6'(offset_bits) + 6'(ib);
        mask  = SET_W'((9'd1 << ib) - 9'd1);
        entry.set_idx = SET_W'(s_tdata >> offset_bits) & mask;
        entry.tag     = (shift >= 6'd32) ? '0 : (s_tdata >> shift);
        entry.alloc   = !s_tuser || write_back;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/sacts_back.sv]
// ----------------------------------------------------------------------------
// sacts_back
// Reads a set, looks the tag up, applies replacement and writes the set back.
// ----------------------------------------------------------------------------
module sacts_back #(
    parameter int MAX_SETS = sacts_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sacts_pkg::MAX_WAYS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sacts_pkg::back_cfg_t                 cfg,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  sacts_pkg::acc_t                      q_data,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sacts_pkg::OUT_DATA_W-1:0]     m_tdata,  // set_index, tag_value, hit_total, miss_total
    output logic                                 m_tuser   // hit
);
    import sacts_pkg::*;

    localparam int RW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW   = $clog2(MAX_WAYS + 1);
    localparam int PW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW   = TAG_W + 1;
    localparam int ROWW = MAX_WAYS * EW;

    typedef logic [RW-1:0] row_tab_t [256];

    function automatic row_tab_t build_rows();
        row_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = RW'(i % MAX_SETS);
        end
        return t;
    endfunction

    localparam row_tab_t ROW_OF = build_rows();

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_MOD  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    acc_t                ent_reg;
    logic [RW-1:0]       row_reg;
    logic [TAG_W-1:0]    tags_reg [MAX_WAYS];
    logic                vld_reg  [MAX_WAYS];
    logic [TAG_W-1:0]    tags_next [MAX_WAYS];
    logic                vld_next  [MAX_WAYS];
    logic                hit_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [WW-1:0]       rem_reg;
    logic [3:0]          cnt_reg;
    logic [CNT_W-1:0]    hits_reg, misses_reg;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                out_hit_reg;
    logic [MAX_SETS-1:0] row_valid_reg;

    logic [ROWW-1:0]     rdata, wdata;
    logic                ram_we, ram_re;
    logic [WW-1:0]       ways;
    logic [TAG_W-1:0]    cur_tag [MAX_WAYS];
    logic                cur_v   [MAX_WAYS];
    logic                found, nfound, hit, empty, need_rand;
    logic [PW-1:0]       pos;
    logic [WW-1:0]       nval;
    logic [WW:0]         r2;
    logic [PW-1:0]       vic;
    logic                take;
    logic [CNT_W-1:0]    hits_next, misses_next;

    // Effective way count: zero counts as one, too many saturates.
    always_comb
    begin
        if (cfg.ways == 4'd0)
        begin
            ways = WW'(1);
        end
        else if (32'(cfg.ways) > MAX_WAYS)
        begin
            ways = WW'(MAX_WAYS);
        end
        else
        begin
            ways = WW'(cfg.ways);
        end
    end

    assign ram_re = (state_reg == S_IDLE) && q_valid;
    assign q_pop  = ram_re;
    assign take   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign ram_we = take;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            wdata[i*EW +: EW] = {vld_reg[i], tags_reg[i]};
        end
    end

    sacts_ram #(
        .WIDTH (ROWW),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (ROW_OF[q_data.set_idx]),
        .rdata (rdata)
    );

    // Lookup and replacement on the row just read.
    always_comb
    begin
        found  = 1'b0;
        nfound = 1'b0;
        pos    = '0;
        nval   = ways;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            cur_tag[i] = rdata[i*EW +: TAG_W];
            cur_v[i]   = row_valid_reg[row_reg] && rdata[i*EW + TAG_W];
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (!found && (WW'(i) < ways) && (!cur_v[i] || cur_tag[i] == ent_reg.tag))
            begin
                found = 1'b1;
                pos   = PW'(i);
            end
            if (!nfound && (WW'(i) < ways) && !cur_v[i])
            begin
                nfound = 1'b1;
                nval   = WW'(i);
            end
        end
        hit       = found && cur_v[pos];
        empty     = found && !cur_v[pos];
        need_rand = !hit && ent_reg.alloc && !empty && (cfg.policy == POL_RANDOM);

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            tags_next[i] = cur_tag[i];
            vld_next[i]  = rdata[i*EW + TAG_W] && row_valid_reg[row_reg];
        end
        if (hit)
        begin
            if (cfg.policy == POL_LRU)
            begin
                for (int i = 0; i < MAX_WAYS - 1; i++)
                begin
                    if ((PW'(i) >= pos) && (WW'(i + 1) < nval))
                    begin
                        tags_next[i] = cur_tag[i + 1];
                    end
                end
                tags_next[PW'(nval - 1'b1)] = ent_reg.tag;
            end
        end
        else if (ent_reg.alloc)
        begin
            if (empty)
            begin
                tags_next[pos] = ent_reg.tag;
                vld_next[pos]  = 1'b1;
            end
            else if (cfg.policy != POL_RANDOM)
            begin
                for (int i = 0; i < MAX_WAYS - 1; i++)
                begin
                    if (WW'(i + 1) < ways)
                    begin
                        tags_next[i] = cur_tag[i + 1];
                    end
                end
                tags_next[PW'(ways - 1'b1)] = ent_reg.tag;
                vld_next[PW'(ways - 1'b1)]  = 1'b1;
            end
        end
    end

    // One remainder bit a cycle, most significant LFSR bit first.
    always_comb
    begin
        r2 = {rem_reg, lfsr_reg[4'd15 - cnt_reg]};
        if (r2 >= (WW + 1)'(ways))
        begin
            r2 = r2 - (WW + 1)'(ways);
        end
        vic = PW'(r2);
    end

    assign hits_next   = hit_reg ? sat_inc(hits_reg) : hits_reg;
    assign misses_next = hit_reg ? misses_reg : sat_inc(misses_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_LOOK;
            S_LOOK:  state_next = need_rand ? S_MOD : S_DONE;
            S_MOD:   if (cnt_reg == 4'd15) state_next = S_DONE;
            S_DONE:  if (take) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            ent_reg <= q_data;
            row_reg <= ROW_OF[q_data.set_idx];
        end
        if (state_reg == S_LOOK)
        begin
            tags_reg <= tags_next;
            vld_reg  <= vld_next;
            hit_reg  <= hit;
            rem_reg  <= '0;
        end
        if (state_reg == S_MOD)
        begin
            rem_reg <= WW'(r2);
            if (cnt_reg == 4'd15)
            begin
                tags_reg[vic] <= ent_reg.tag;
                vld_reg[vic]  <= 1'b1;
            end
        end
        if (take)
        begin
            out_data_reg <= {misses_next, hits_next, ent_reg.tag, ent_reg.set_idx};
            out_hit_reg  <= hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lfsr_reg      <= LFSR_SEED;
            cnt_reg       <= 4'd0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOK)
            begin
                cnt_reg <= 4'd0;
                if (need_rand)
                begin
                    lfsr_reg <= lfsr_next(lfsr_reg);
                end
            end
            else if (state_reg == S_MOD)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (take)
            begin
                hits_reg               <= hits_next;
                misses_reg             <= misses_next;
                row_valid_reg[row_reg] <= 1'b1;
                out_valid_reg          <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

    a_hits_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg >= $past(hits_reg))
        else $error("hit total went down");

    a_write_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DONE) && !ram_re)
        else $error("set written outside the write-back step");

    a_lfsr_held_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |=> $stable(lfsr_reg))
        else $error("LFSR moved during victim selection");

endmodule

[sim/set_assoc_cache_tag_store_checker.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_checker
// Watches the access, result and register channels of the tag store, keeps
// its own copy of the tag store and compares every result item with it.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_checker
    import sacts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [ADDR_W-1:0]       s_tdata,
    input  logic                    s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    m_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output int                      lookups_pending,
    output int                      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS = MAX_SETS_DEF;
    localparam int WAYS = MAX_WAYS_DEF;

    typedef struct {
        logic              hit;
        logic [SET_W-1:0]  set_idx;
        logic [TAG_W-1:0]  tag;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } lookup_t;

    lookup_t            lookup_q[$];
    logic [TAG_W-1:0]   tag_mem[0:SETS*WAYS-1];
    bit                 valid_mem[0:SETS*WAYS-1];
    logic [LFSR_W-1:0]  lfsr;
    logic [CNT_W-1:0]   hit_cnt;
    logic [CNT_W-1:0]   miss_cnt;
    logic [1:0]         policy;
    logic               wb;
    logic [4:0]         off_bits;
    logic [3:0]         idx_bits;
    logic [3:0]         way_cnt;

    assign lookups_pending = lookup_q.size();

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        return {v[0] ^ v[2] ^ v[3] ^ v[5], v[LFSR_W-1:1]};
    endfunction

    task automatic predict_lookup(input logic cmd, input logic [ADDR_W-1:0] addr,
                                  output lookup_t res);
        int               ib;
        int               ways;
        int               shamt;
        int               base;
        int               pos;
        int               n;
        bit               hit;
        bit               empty;
        bit               alloc;
        logic [31:0]      setv;
        logic [TAG_W-1:0] tag;
        ib    = idx_bits > 8 ? 8 : idx_bits;
        ways  = way_cnt == 0 ? 1 : (way_cnt > WAYS ? WAYS : way_cnt);
        setv  = (addr >> off_bits) & ((32'd1 << ib) - 32'd1);
        shamt = off_bits + ib;
        tag   = shamt >= 32 ? '0 : addr >> shamt;
        base  = (setv % SETS) * WAYS;
        alloc = (cmd == 1'b0) || wb;
        hit   = 0;
        empty = 0;
        pos   = ways;
        for (int i = 0; i < ways; i++)
        begin
            if (!valid_mem[base+i])
            begin
                empty = 1;
                pos = i;
                break;
            end
            if (tag_mem[base+i] == tag)
            begin
                hit = 1;
                pos = i;
                break;
            end
        end
        if (hit)
        begin
            hit_cnt = sat_inc(hit_cnt);
            // LRU: the entry that hit moves to the end of the valid prefix.
            if (policy == POL_LRU)
            begin
                n = 0;
                while (n < ways && valid_mem[base+n])
                    n++;
                for (int i = pos; i + 1 < n; i++)
                    tag_mem[base+i] = tag_mem[base+i+1];
                tag_mem[base+n-1] = tag;
            end
        end
        else
        begin
            miss_cnt = sat_inc(miss_cnt);
            if (alloc)
            begin
                if (empty)
                begin
                    tag_mem[base+pos]   = tag;
                    valid_mem[base+pos] = 1;
                end
                else if (policy == POL_RANDOM)
                begin
                    lfsr = lfsr_step(lfsr);
                    n = lfsr % ways;
                    tag_mem[base+n]   = tag;
                    valid_mem[base+n] = 1;
                end
                else
                begin
                    for (int i = 0; i + 1 < ways; i++)
                        tag_mem[base+i] = tag_mem[base+i+1];
                    tag_mem[base+ways-1]   = tag;
                    valid_mem[base+ways-1] = 1;
                end
            end
        end
        res.hit     = hit;
        res.set_idx = setv[SET_W-1:0];
        res.tag     = tag;
        res.hits    = hit_cnt;
        res.misses  = miss_cnt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t exp_r;
        lookup_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SETS*WAYS; i++)
            begin
                tag_mem[i]   = '0;
                valid_mem[i] = 0;
            end
            lfsr     = LFSR_SEED;
            hit_cnt  = '0;
            miss_cnt = '0;
            policy   = POL_FIFO;
            wb       = 1'b1;
            off_bits = 5'd6;
            idx_bits = 4'd0;
            way_cnt  = 4'd8;
            lookup_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POLICY: policy   = cfg_data[1:0];
                    REG_WB:     wb       = cfg_data[0];
                    REG_OFFSET: off_bits = cfg_data[4:0];
                    REG_INDEX:  idx_bits = cfg_data[3:0];
                    REG_WAYS:   way_cnt  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_lookup(s_tuser, s_tdata, exp_r);
                lookup_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready)
            begin
                got.hit     = m_tuser;
                got.set_idx = m_tdata[SET_W-1:0];
                got.tag     = m_tdata[SET_W +: TAG_W];
                got.hits    = m_tdata[SET_W+TAG_W +: CNT_W];
                got.misses  = m_tdata[SET_W+TAG_W+CNT_W +: CNT_W];
                if (lookup_q.size() == 0)
                begin
                    $display("%0t: result item with none expected: hit %0b set %0h tag %0h",
                             $time, got.hit, got.set_idx, got.tag);
                    fail_count++;
                end
                else
                begin
                    exp_r = lookup_q.pop_front();
                    if (got.hit !== exp_r.hit)
                    begin
                        $display("%0t: hit expected %0b got %0b", $time, exp_r.hit, got.hit);
                        fail_count++;
                    end
                    if (got.set_idx !== exp_r.set_idx)
                    begin
                        $display("%0t: set_index expected %0h got %0h",
                                 $time, exp_r.set_idx, got.set_idx);
                        fail_count++;
                    end
                    if (got.tag !== exp_r.tag)
                    begin
                        $display("%0t: tag_value expected %0h got %0h",
                                 $time, exp_r.tag, got.tag);
                        fail_count++;
                    end
                    if (got.hits !== exp_r.hits)
                    begin
                        $display("%0t: hit_total expected %0d got %0d",
                                 $time, exp_r.hits, got.hits);
                        fail_count++;
                    end
                    if (got.misses !== exp_r.misses)
                    begin
                        $display("%0t: miss_total expected %0d got %0d",
                                 $time, exp_r.misses, got.misses);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_set_assoc_cache_tag_store.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_store
// Stimulus and verdict for the set-associative cache tag store.
// ----------------------------------------------------------------------------
// The top drives accesses and register writes and applies random back
// pressure; the checker beside the block predicts every result item and
// counts mismatches. A directed opening covers the reset settings, the
// replacement policies and the odd register values; random phases follow.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_store;
    import sacts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata;     // address
    logic                   s_tuser;     // command
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;     // set_index, tag_value, hit_total, miss_total
    logic                   m_tuser;     // hit
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     lookups_pending;
    int                     fail_count;

    // Request from the sender for one long hold-off on the result side.
    bit                     long_hold_req;
    // The current address split, mirrored so that addresses can be aimed at
    // a few sets and tags and so produce hits.
    int                     cur_off;
    int                     cur_ib;

    set_assoc_cache_tag_store dut (.*);

    set_assoc_cache_tag_store_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: a random wait before each item, and on request one long
    // stretch with m_tready low so that the internal queue fills and the
    // block stalls its input.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (long_hold_req)
            begin
                gap += 300;
                long_hold_req = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    // Registers change only once the block has drained, after a further wait.
    task automatic set_config(input int pol, input int wbk, input int off,
                              input int ib, input int ways);
        s_tvalid <= 1'b0;
        wait (lookups_pending == 0);
        repeat (40) @(negedge clk);
        cfg_write(REG_POLICY, pol);
        cfg_write(REG_WB, wbk);
        cfg_write(REG_OFFSET, off);
        cfg_write(REG_INDEX, ib);
        cfg_write(REG_WAYS, ways);
        cfg_valid <= 1'b0;
        cur_off = off & 31;
        cur_ib  = (ib & 15) > 8 ? 8 : (ib & 15);
    endtask

    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr, input bit paced);
        int gap;
        gap = paced ? $urandom_range(0, 4) : 0;
        if (paced && $urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= addr;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // Most addresses reuse a handful of tags over a few sets so that hits,
    // evictions and LRU reordering all happen; the rest are fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [63:0] a;
        logic [63:0] low_mask;
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        low_mask = (64'd1 << cur_off) - 64'd1;
        a = (64'($urandom_range(0, 11)) << (cur_off + cur_ib))
          | ((64'($urandom_range(0, 3)) & ((64'd1 << cur_ib) - 64'd1)) << cur_off)
          | (64'($urandom) & low_mask);
        return a[ADDR_W-1:0];
    endfunction

    initial
    begin
        int n_items;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        long_hold_req = 0;
        cur_off       = 6;
        cur_ib        = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed opening at the reset settings: a miss, a hit, the extreme
        // addresses, and nine tags into one fully associative set to evict.
        send_access(1'b0, 32'h0000_0000, 1);
        send_access(1'b0, 32'h0000_0000, 1);
        send_access(1'b1, 32'hFFFF_FFFF, 1);
        send_access(1'b0, 32'hFFFF_FFFF, 1);
        for (int i = 1; i <= 9; i++)
            send_access(1'b0, 32'(i) << 6, 1);
        send_access(1'b0, 32'h0000_0040, 1);

        // Write-through: a write miss allocates nothing, so the read misses.
        set_config(POL_FIFO, 0, 4, 2, 2);
        send_access(1'b1, 32'h0000_1230, 1);
        send_access(1'b0, 32'h0000_1230, 1);
        // Policy code three behaves as FIFO; index bits above eight saturate.
        set_config(3, 1, 0, 15, 1);
        send_access(1'b0, 32'hABCD_EF12, 1);
        send_access(1'b0, 32'hABCD_EF12, 1);
        // Offset 31 with eight index bits: the tag shift reaches 32 or more.
        set_config(POL_LRU, 1, 31, 8, 0);
        send_access(1'b0, 32'h8000_0000, 1);
        send_access(1'b0, 32'h7FFF_FFFF, 1);
        // Way count above the maximum saturates.
        set_config(POL_RANDOM, 1, 0, 0, 15);
        for (int i = 0; i < 3; i++)
            send_access(1'b0, $urandom, 1);

        // Random phases, extremes first, then random settings.
        for (int p = 0; p < 14; p++)
        begin
            case (p)
                0:  set_config(POL_LRU, 1, 6, 0, 8);
                1:  set_config(POL_RANDOM, 1, 2, 1, 3);
                2:  set_config(POL_FIFO, 1, 0, 8, 8);
                3:  set_config(POL_LRU, 0, 31, 0, 1);
                4:  set_config(POL_RANDOM, 1, 5, 2, 8);
                default:
                    set_config($urandom_range(0, 3), $urandom_range(0, 1),
                               $urandom_range(0, 99) < 10 ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 12),
                               $urandom_range(0, 31), $urandom_range(0, 31));
            endcase
            n_items = 140;
            for (int i = 0; i < n_items; i++)
            begin
                // Once the receiver holds off for a long stretch; once the
                // sender pauses until every result has come back.
                if (p == 2 && i == 20)
                    long_hold_req = 1;
                if (p == 4 && i == 70)
                begin
                    s_tvalid <= 1'b0;
                    wait (lookups_pending == 0);
                    @(negedge clk);
                end
                send_access($urandom_range(0, 1), pick_address(),
                            !(p == 6 && i < 60));
            end
        end
        s_tvalid <= 1'b0;

        wait (lookups_pending == 0);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[set_assoc_cache_tag_store.f]
design/sacts_pkg.sv
design/sacts_ram.sv
design/sacts_front.sv
design/sacts_back.sv
design/set_assoc_cache_tag_store.sv
sim/set_assoc_cache_tag_store_checker.sv
sim/tb_set_assoc_cache_tag_store.sv
